FILE: rtl/rotated_box_pick_nearest_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the nearest rotated box picker
// Shared property forms: a same-cycle implication and a next-cycle one.
// ----------------------------------------------------------------------------
`ifndef ROTATED_BOX_PICK_NEAREST_MACROS_SVH
`define ROTATED_BOX_PICK_NEAREST_MACROS_SVH

// Check that cons holds in the cycle where ante holds.
`define RBPN_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check that cons holds in the cycle after ante holds.
`define RBPN_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/rbpn_pkg.sv
// ----------------------------------------------------------------------------
// rbpn_pkg
// Types and constants shared by the nearest rotated box picker.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package rbpn_pkg;

    localparam int Q_W      = 32;
    localparam int EXT_W    = 31;
    localparam int ANG_W    = 16;
    localparam int DIFF_W   = 33;
    localparam int SIN_W    = 18;
    localparam int OBJ_W    = 10;

    localparam int IN_TDATA_W  = 240;
    localparam int OUT_TDATA_W = 16;

    localparam int PH_LAT  = 4;
    localparam int SIN_LAT = 4;
    localparam int ROT_LAT = 2;

    localparam logic [16:0] POLY_A = 17'd102944;
    localparam logic [15:0] POLY_B = 16'd42048;
    localparam logic [12:0] POLY_C = 13'd4640;

    localparam logic [14:0] QUARTER_TURN = 15'd16384;
    localparam logic [ANG_W-1:0] COS_OFFSET = 16'd16384;

    localparam logic signed [Q_W-1:0] DEPTH_MIN = {1'b1, {(Q_W-1){1'b0}}};

    typedef struct packed {
        logic signed [DIFF_W-1:0] dx;
        logic signed [DIFF_W-1:0] dy;
        logic [EXT_W-1:0]         hw;
        logic [EXT_W-1:0]         hh;
        logic signed [Q_W-1:0]    depth;
        logic [ANG_W-1:0]         angle;
        logic                     last;
    } t_item;

    typedef struct packed {
        logic                  hit;
        logic                  last;
        logic signed [Q_W-1:0] depth;
    } t_hit;

endpackage

`default_nettype wire

FILE: rtl/rbpn_phase.sv
// ----------------------------------------------------------------------------
// rbpn_phase
// Quantizes the binary angle to the trig table grid and maps the step back
// to a 16-bit phase; the divide by the table depth uses a reciprocal product
// with a one-step correction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rbpn_phase
    import rbpn_pkg::*;
#(
    parameter int TRIG_TABLE_DEPTH = 1024
) (
    input  wire logic             i_clk,
    input  wire logic             i_en,
    input  wire logic [ANG_W-1:0] i_angle,
    output logic      [ANG_W-1:0] o_phase
);

    localparam int        D_W    = $clog2(TRIG_TABLE_DEPTH + 1);
    localparam int        IDX_W  = $clog2(TRIG_TABLE_DEPTH);
    localparam longint    RECIP  = (64'd1 << 32) / TRIG_TABLE_DEPTH;
    localparam int        R_W    = $clog2(RECIP + 1);
    localparam int        PROD_W = ANG_W + D_W;

    localparam logic [D_W-1:0] DEPTH_C = D_W'(TRIG_TABLE_DEPTH);
    localparam logic [R_W-1:0] RECIP_C = R_W'(RECIP);

    logic [PROD_W-1:0]      r_prod;
    logic [IDX_W-1:0]       r_idx;
    logic [ANG_W-1:0]       r_q0;
    logic [ANG_W-1:0]       r_q1;
    logic [IDX_W+ANG_W-1:0] r_num;
    logic [31:0]            r_qd;
    logic [ANG_W-1:0]       r_phase;

    logic [IDX_W-1:0] w_idx;
    logic [47:0]      w_qm;
    logic [31:0]      w_rem;

    assign w_idx = r_prod[ANG_W +: IDX_W];
    assign w_qm  = 48'(w_idx) * 48'(RECIP_C);
    assign w_rem = 32'(r_num) - r_qd;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod  <= PROD_W'(i_angle) * PROD_W'(DEPTH_C);
            r_idx   <= w_idx;
            r_q0    <= w_qm[31:16];
            r_q1    <= r_q0;
            r_num   <= {r_idx, {ANG_W{1'b0}}};
            r_qd    <= 32'(r_q0) * 32'(DEPTH_C);
            r_phase <= r_q1 + ANG_W'(w_rem >= 32'(DEPTH_C));
        end
    end

    assign o_phase = r_phase;

endmodule

`default_nettype wire

FILE: rtl/rbpn_sine.sv
// ----------------------------------------------------------------------------
// rbpn_sine
// Q16 sine of a 16-bit phase from the quarter wave odd polynomial,
// one product per stage.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rbpn_sine
    import rbpn_pkg::*;
(
    input  wire logic                    i_clk,
    input  wire logic                    i_en,
    input  wire logic [ANG_W-1:0]        i_phase,
    output logic signed [SIN_W-1:0]      o_sine
);

    logic [14:0] w_r;
    logic [16:0] w_z;
    logic [33:0] w_zz_prod;
    logic [29:0] w_t1_prod;
    logic [15:0] w_bmt;
    logic [32:0] w_t2_prod;
    logic [16:0] w_amt;
    logic [33:0] w_s_prod;
    logic [16:0] w_s;

    logic [16:0] r_s1_z;
    logic [16:0] r_s1_zz;
    logic        r_s1_neg;
    logic [16:0] r_s2_z;
    logic [16:0] r_s2_zz;
    logic [12:0] r_s2_t1;
    logic        r_s2_neg;
    logic [16:0] r_s3_z;
    logic [15:0] r_s3_t2;
    logic        r_s3_neg;
    logic signed [SIN_W-1:0] r_sine;

    always_comb begin
        w_r = {1'b0, i_phase[13:0]};
        if (i_phase[14]) begin
            w_r = QUARTER_TURN - w_r;
        end
        w_z       = {w_r, 2'b00};
        w_zz_prod = 34'(w_z) * 34'(w_z);
        w_t1_prod = 30'(POLY_C) * 30'(r_s1_zz);
        w_bmt     = POLY_B - 16'(r_s2_t1);
        w_t2_prod = 33'(w_bmt) * 33'(r_s2_zz);
        w_amt     = POLY_A - 17'(r_s3_t2);
        w_s_prod  = 34'(r_s3_z) * 34'(w_amt);
        w_s       = w_s_prod[32:16];
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s1_z   <= w_z;
            r_s1_zz  <= w_zz_prod[32:16];
            r_s1_neg <= i_phase[15];
            r_s2_z   <= r_s1_z;
            r_s2_zz  <= r_s1_zz;
            r_s2_t1  <= w_t1_prod[28:16];
            r_s2_neg <= r_s1_neg;
            r_s3_z   <= r_s2_z;
            r_s3_t2  <= w_t2_prod[31:16];
            r_s3_neg <= r_s2_neg;
            r_sine   <= r_s3_neg ? -$signed({1'b0, w_s}) : $signed({1'b0, w_s});
        end
    end

    assign o_sine = r_sine;

endmodule

`default_nettype wire

FILE: rtl/rbpn_rotate.sv
// ----------------------------------------------------------------------------
// rbpn_rotate
// Rotates the point offset by the object angle and tests the result against
// the box extents, bounds included.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rbpn_rotate
    import rbpn_pkg::*;
(
    input  wire logic                    i_clk,
    input  wire logic                    i_en,
    input  wire t_item                   i_item,
    input  wire logic signed [SIN_W-1:0] i_sin,
    input  wire logic signed [SIN_W-1:0] i_cos,
    output t_hit                         o_hit
);

    localparam int P_W = DIFF_W + SIN_W;
    localparam int F_W = P_W + 1 - 16;

    logic signed [P_W-1:0] r_pxc;
    logic signed [P_W-1:0] r_pys;
    logic signed [P_W-1:0] r_pxs;
    logic signed [P_W-1:0] r_pyc;
    logic [EXT_W-1:0]      r_hw;
    logic [EXT_W-1:0]      r_hh;
    logic signed [Q_W-1:0] r_depth;
    logic                  r_last;
    t_hit                  r_hit;

    logic [P_W:0]          w_sx;
    logic [P_W:0]          w_sy;
    logic signed [F_W-1:0] w_fx;
    logic signed [F_W-1:0] w_fy;
    logic signed [F_W-1:0] w_hw;
    logic signed [F_W-1:0] w_hh;
    logic                  w_in;

    always_comb begin
        w_sx = {r_pxc[P_W-1], r_pxc} - {r_pys[P_W-1], r_pys};
        w_sy = {r_pxs[P_W-1], r_pxs} + {r_pyc[P_W-1], r_pyc};
        w_fx = $signed(w_sx[P_W:16]);
        w_fy = $signed(w_sy[P_W:16]);
        w_hw = $signed({{(F_W-EXT_W){1'b0}}, r_hw});
        w_hh = $signed({{(F_W-EXT_W){1'b0}}, r_hh});
        w_in = (w_fx >= -w_hw) && (w_fx <= w_hw) && (w_fy >= -w_hh) && (w_fy <= w_hh);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_pxc       <= i_item.dx * i_cos;
            r_pys       <= i_item.dy * i_sin;
            r_pxs       <= i_item.dx * i_sin;
            r_pyc       <= i_item.dy * i_cos;
            r_hw        <= i_item.hw;
            r_hh        <= i_item.hh;
            r_depth     <= i_item.depth;
            r_last      <= i_item.last;
            r_hit.hit   <= w_in;
            r_hit.last  <= r_last;
            r_hit.depth <= r_depth;
        end
    end

    assign o_hit = r_hit;

endmodule

`default_nettype wire

FILE: rtl/rotated_box_pick_nearest.sv
// Throughput: one item per cycle; the pipeline (input register, angle quantizer 4,
// sine units 4, rotation and bounds 2, pick 1) stalls only when a last item
// meets an untaken result in the output register.
// Reset: synchronous, active low; clears stage valid flags, the pick state,
// the object counter and the output valid. No memory, no clearing pass.
// ----------------------------------------------------------------------------
// rotated_box_pick_nearest
// Streams scene objects, finds the frontmost oriented box holding the query
// point and reports its position in the pass on the last object.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "rotated_box_pick_nearest_macros.svh"

module rotated_box_pick_nearest
    import rbpn_pkg::*;
#(
    parameter int MAX_OBJECTS      = 1024,
    parameter int TRIG_TABLE_DEPTH = 1024
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_s_axis_tvalid,
    output logic                        o_s_axis_tready,
    // query_x, query_y, center_x, center_y, depth_z, half_width, half_height,
    // angle_units, zero pad
    input  wire logic [IN_TDATA_W-1:0]  i_s_axis_tdata,
    input  wire logic                   i_s_axis_tlast,
    output logic                        o_m_axis_tvalid,
    input  wire logic                   i_m_axis_tready,
    // object_index, zero pad
    output logic [OUT_TDATA_W-1:0]      o_m_axis_tdata,
    // found
    output logic [0:0]                  o_m_axis_tuser
);

    localparam int OBJ_TOP   = (1 << OBJ_W) - 1;
    localparam int COUNT_CAP = (MAX_OBJECTS - 1 > OBJ_TOP) ? OBJ_TOP : MAX_OBJECTS - 1;
    localparam int CNT_W     = $clog2(COUNT_CAP + 1);
    localparam int ITEM_TAP  = PH_LAT + SIN_LAT;
    localparam int VLD_TAP   = ITEM_TAP + ROT_LAT;

    logic signed [Q_W-1:0] w_qx;
    logic signed [Q_W-1:0] w_qy;
    logic signed [Q_W-1:0] w_cx;
    logic signed [Q_W-1:0] w_cy;
    t_item                 w_item;
    logic [ANG_W-1:0]      w_phase;
    logic [ANG_W-1:0]      w_cos_phase;
    logic signed [SIN_W-1:0] w_sin;
    logic signed [SIN_W-1:0] w_cos;
    t_hit                  w_hit;
    logic                  w_en;
    logic                  w_fire;
    logic                  w_take;
    logic                  w_sel_any;
    logic [OBJ_W-1:0]      w_sel_idx;

    t_item                 r_item [ITEM_TAP+1];
    logic [VLD_TAP:0]      r_vld;
    logic                  r_any;
    logic signed [Q_W-1:0] r_best_depth;
    logic [OBJ_W-1:0]      r_best_idx;
    logic [CNT_W-1:0]      r_cnt;
    logic                  r_out_valid;
    logic                  r_found;
    logic [OBJ_W-1:0]      r_obj_idx;

    logic                  n_any;
    logic signed [Q_W-1:0] n_best_depth;
    logic [OBJ_W-1:0]      n_best_idx;
    logic [CNT_W-1:0]      n_cnt;
    logic                  n_out_valid;
    logic                  n_found;
    logic [OBJ_W-1:0]      n_obj_idx;

    always_comb begin
        w_qx         = $signed(i_s_axis_tdata[31:0]);
        w_qy         = $signed(i_s_axis_tdata[63:32]);
        w_cx         = $signed(i_s_axis_tdata[95:64]);
        w_cy         = $signed(i_s_axis_tdata[127:96]);
        w_item.dx    = $signed({w_qx[Q_W-1], w_qx}) - $signed({w_cx[Q_W-1], w_cx});
        w_item.dy    = $signed({w_qy[Q_W-1], w_qy}) - $signed({w_cy[Q_W-1], w_cy});
        w_item.depth = $signed(i_s_axis_tdata[159:128]);
        w_item.hw    = i_s_axis_tdata[190:160];
        w_item.hh    = i_s_axis_tdata[221:191];
        w_item.angle = i_s_axis_tdata[237:222];
        w_item.last  = i_s_axis_tlast;
    end

    assign w_en = !(r_vld[VLD_TAP] && w_hit.last && r_out_valid && !i_m_axis_tready);
    assign o_s_axis_tready = w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[VLD_TAP-1:0], i_s_axis_tvalid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_item[0] <= w_item;
            for (int k = 1; k <= ITEM_TAP; k++) begin
                r_item[k] <= r_item[k-1];
            end
        end
    end

    rbpn_phase #(
        .TRIG_TABLE_DEPTH (TRIG_TABLE_DEPTH)
    ) u_phase (
        .i_clk   (i_clk),
        .i_en    (w_en),
        .i_angle (r_item[0].angle),
        .o_phase (w_phase)
    );

    assign w_cos_phase = w_phase + COS_OFFSET;

    rbpn_sine u_sin (
        .i_clk   (i_clk),
        .i_en    (w_en),
        .i_phase (w_phase),
        .o_sine  (w_sin)
    );

    rbpn_sine u_cos (
        .i_clk   (i_clk),
        .i_en    (w_en),
        .i_phase (w_cos_phase),
        .o_sine  (w_cos)
    );

    rbpn_rotate u_rotate (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_item (r_item[ITEM_TAP]),
        .i_sin  (w_sin),
        .i_cos  (w_cos),
        .o_hit  (w_hit)
    );

    assign w_fire    = w_en && r_vld[VLD_TAP];
    assign w_take    = w_hit.hit && (!r_any || (w_hit.depth > r_best_depth));
    assign w_sel_any = r_any || w_take;
    assign w_sel_idx = w_take ? OBJ_W'(r_cnt) : r_best_idx;

    always_comb begin
        n_any        = r_any;
        n_best_depth = r_best_depth;
        n_best_idx   = r_best_idx;
        n_cnt        = r_cnt;
        n_out_valid  = r_out_valid && !i_m_axis_tready;
        n_found      = r_found;
        n_obj_idx    = r_obj_idx;
        if (w_fire) begin
            if (w_hit.last) begin
                n_out_valid  = 1'b1;
                n_found      = w_sel_any;
                n_obj_idx    = w_sel_any ? w_sel_idx : '0;
                n_any        = 1'b0;
                n_best_depth = DEPTH_MIN;
                n_best_idx   = '0;
                n_cnt        = '0;
            end else begin
                if (w_take) begin
                    n_any        = 1'b1;
                    n_best_depth = w_hit.depth;
                    n_best_idx   = w_sel_idx;
                end
                if (r_cnt < CNT_W'(COUNT_CAP)) begin
                    n_cnt = CNT_W'(r_cnt + 1'b1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_any        <= 1'b0;
            r_best_depth <= DEPTH_MIN;
            r_best_idx   <= '0;
            r_cnt        <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_any        <= n_any;
            r_best_depth <= n_best_depth;
            r_best_idx   <= n_best_idx;
            r_cnt        <= n_cnt;
            r_out_valid  <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_found   <= n_found;
        r_obj_idx <= n_obj_idx;
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {{(OUT_TDATA_W-OBJ_W){1'b0}}, r_obj_idx};
    assign o_m_axis_tuser  = r_found;

    `RBPN_ASSERT_IMP(a_miss_index_zero, i_clk, i_rst_n, o_m_axis_tvalid && !o_m_axis_tuser[0], o_m_axis_tdata == '0, "result without hit carries nonzero index")
    `RBPN_ASSERT_NXT(a_last_gives_result, i_clk, i_rst_n, w_fire && w_hit.last, o_m_axis_tvalid, "last item gave no result")
    `RBPN_ASSERT_NXT(a_last_clears_state, i_clk, i_rst_n, w_fire && w_hit.last, (r_cnt == '0) && !r_any, "pick state not cleared after last item")
    `RBPN_ASSERT_IMP(a_stall_only_on_full, i_clk, i_rst_n, !o_s_axis_tready, o_m_axis_tvalid && !i_m_axis_tready, "input stalled while output free")

endmodule

`default_nettype wire
